### src/nnis_pkg.sv
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared constants and types of the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

  // Source image geometry.
  localparam int SRC_WIDTH  = 64;
  localparam int SRC_HEIGHT = 64;
  localparam int IMG_SIZE   = SRC_WIDTH * SRC_HEIGHT;
  localparam int ADDR_W     = (IMG_SIZE > 1) ? $clog2(IMG_SIZE) : 1;
  localparam int SX_W       = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
  localparam int SY_W       = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;

  // Register and field widths.
  localparam int OW_W  = 8;
  localparam int OH_W  = 9;
  localparam int PIX_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 1'd1;

  // Register reset values.
  localparam logic [OW_W-1:0] OUT_WIDTH_RESET  = 8'd180;
  localparam logic [OH_W-1:0] OUT_HEIGHT_RESET = 9'd126;

  // Scaled source positions before clamping: counter times source size.
  localparam int QX_W  = $clog2((1 << OW_W) * SRC_WIDTH);
  localparam int QY_W  = $clog2((1 << OH_W) * SRC_HEIGHT);
  localparam int DIV_W = (QY_W > QX_W) ? QY_W : QX_W;
  localparam int DSR_W = (OH_W > OW_W) ? OH_W : OW_W;

  typedef struct packed {
    logic             valid;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DSR_W-1:0] rem;
  } div_rsp_t;

endpackage

### src/nnis_div.sv
// ----------------------------------------------------------------------------
// nnis_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnis_div (
  input  logic               clk,
  input  logic               rst_n,
  input  nnis_pkg::div_req_t req,
  output nnis_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(nnis_pkg::DIV_W + 1);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [nnis_pkg::DIV_W-1:0]  dvd_r;
  logic [nnis_pkg::DSR_W-1:0]  dsr_r;
  logic [nnis_pkg::DSR_W-1:0]  rem_r;
  logic [nnis_pkg::DSR_W-1:0]  rem_nxt;
  logic [nnis_pkg::DSR_W:0]    trial;
  logic                        qbit;

  always_comb begin
    trial = {rem_r, dvd_r[nnis_pkg::DIV_W-1]};
    qbit  = (trial >= {1'b0, dsr_r});
    if (qbit) begin
      rem_nxt = nnis_pkg::DSR_W'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[nnis_pkg::DSR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // Done pulses for one cycle after the last quotient bit.
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (!busy_r && req.valid) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(nnis_pkg::DIV_W);
        dvd_r  <= req.dividend;
        dsr_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        // The quotient bits shift in where the dividend bits leave.
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[nnis_pkg::DIV_W-2:0], qbit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;
  assign rsp.rem  = rem_r;

endmodule

### src/nearest_neighbor_image_scaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Nearest-neighbor scaler from a stored RGB565 source image to an output window.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_mode, in_pixel_in) carries one word
// per item. A word with in_mode low writes one source pixel at the load pointer,
// which walks the source image in raster order and wraps after the last pixel.
// A word with in_mode high asks for the next pixel of the output window; the
// result word (out_pixel_out, out_row_end, out_frame_end) leaves on the output
// channel, which the receiver holds back with out_stall.
// Loads and emits are taken at one word per cycle while in_stall is low. An emit
// result passes through the image memory read register and then the output
// register. Source indexes are stepped incrementally, so no division is done
// per pixel.
// After reset, and after every write on the configuration port, a serial
// divider recomputes the stepping state from the window size and the current
// output position; in_stall is high while this runs. Configuration writes are
// always taken (cfg_ready is tied high).
// When the receiver stalls, one result waits in the output register and a
// second in the memory read register; the receiver's stall reaches the input
// only when both are full.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [nnis_pkg::PIX_W-1:0]      in_pixel_in,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [nnis_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                            out_row_end,
  output logic                            out_frame_end,
  // Configuration port.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = nnis_pkg::ADDR_W;
  localparam int OW = nnis_pkg::OW_W;
  localparam int OH = nnis_pkg::OH_W;
  localparam int QX = nnis_pkg::QX_W;
  localparam int QY = nnis_pkg::QY_W;
  localparam int DV = nnis_pkg::DIV_W;
  localparam int DS = nnis_pkg::DSR_W;

  typedef enum logic [2:0] {
    RC_IDLE,
    RC_XPOS,
    RC_XSTEP,
    RC_YPOS,
    RC_YSTEP
  } rc_state_t;

  // The source image memory.
  logic [nnis_pkg::PIX_W-1:0] img_mem [nnis_pkg::IMG_SIZE];
  logic [nnis_pkg::PIX_W-1:0] rd_data_r;

  // Configuration registers.
  logic [OW-1:0] out_width_r;
  logic [OH-1:0] out_height_r;
  logic          dirty_r;

  // Output position and the incremental source index state.
  logic [AW-1:0] load_ptr_r;
  logic [OW-1:0] col_r;
  logic [OH-1:0] row_r;
  logic [QX-1:0] sx_r;
  logic [OW-1:0] remx_r;
  logic [QX-1:0] stepqx_r;
  logic [OW-1:0] steprx_r;
  logic [QY-1:0] sy_r;
  logic [OH-1:0] remy_r;
  logic [QY-1:0] stepqy_r;
  logic [OH-1:0] stepry_r;

  rc_state_t     rc_state_r;
  logic          rc_go_r;

  // Read and output stages.
  logic          pend_r;
  logic          pend_row_end_r;
  logic          pend_frame_end_r;
  logic          out_valid_r;
  logic [nnis_pkg::PIX_W-1:0] out_pixel_r;
  logic          out_row_end_r;
  logic          out_frame_end_r;

  nnis_pkg::div_req_t div_req;
  nnis_pkg::div_rsp_t div_rsp;

  logic [OW-1:0] weff;
  logic [OH-1:0] heff;
  logic          busy;
  logic          accept;
  logic          accept_load;
  logic          accept_emit;
  logic          pend_move;
  logic          row_end;
  logic          frame_end;
  logic [nnis_pkg::SX_W-1:0] sx_clamp;
  logic [nnis_pkg::SY_W-1:0] sy_clamp;
  logic [AW-1:0] rd_addr;
  logic [OW:0]   sumx;
  logic          wrapx;
  logic [OW-1:0] remx_nxt;
  logic [QX-1:0] sx_nxt;
  logic [OH:0]   sumy;
  logic          wrapy;
  logic [OH-1:0] remy_nxt;
  logic [QY-1:0] sy_nxt;

  // A zero window size acts as one.
  assign weff = (out_width_r == '0) ? OW'(1) : out_width_r;
  assign heff = (out_height_r == '0) ? OH'(1) : out_height_r;

  assign busy        = dirty_r || (rc_state_r != RC_IDLE);
  assign in_stall    = busy || (pend_r && out_valid_r && out_stall);
  assign accept      = in_valid && !in_stall;
  assign accept_load = accept && !in_mode;
  assign accept_emit = accept && in_mode;
  assign pend_move   = pend_r && (!out_valid_r || !out_stall);
  assign cfg_ready   = 1'b1;

  // End flags; a counter beyond a shrunk window counts as being at the end.
  assign row_end   = ({1'b0, col_r} + 1'b1) >= {1'b0, weff};
  assign frame_end = row_end && (({1'b0, row_r} + 1'b1) >= {1'b0, heff});

  // Clamp the scaled positions to the last source column and row.
  assign sx_clamp = (sx_r >= QX'(nnis_pkg::SRC_WIDTH)) ?
                    nnis_pkg::SX_W'(nnis_pkg::SRC_WIDTH - 1) : sx_r[nnis_pkg::SX_W-1:0];
  assign sy_clamp = (sy_r >= QY'(nnis_pkg::SRC_HEIGHT)) ?
                    nnis_pkg::SY_W'(nnis_pkg::SRC_HEIGHT - 1) : sy_r[nnis_pkg::SY_W-1:0];
  assign rd_addr  = AW'(AW'(sy_clamp) * AW'(nnis_pkg::SRC_WIDTH)) + AW'(sx_clamp);

  // One step of the column and row stepping: add the step quotient and
  // remainder, and carry once when the remainder passes the window size.
  always_comb begin
    sumx     = {1'b0, remx_r} + {1'b0, steprx_r};
    wrapx    = (sumx >= {1'b0, weff});
    remx_nxt = wrapx ? OW'(sumx - {1'b0, weff}) : sumx[OW-1:0];
    sx_nxt   = sx_r + stepqx_r + QX'(wrapx);
    sumy     = {1'b0, remy_r} + {1'b0, stepry_r};
    wrapy    = (sumy >= {1'b0, heff});
    remy_nxt = wrapy ? OH'(sumy - {1'b0, heff}) : sumy[OH-1:0];
    sy_nxt   = sy_r + stepqy_r + QY'(wrapy);
  end

  // Divider requests: the current position and a one-pixel step, for each axis.
  always_comb begin
    div_req.valid    = rc_go_r;
    div_req.dividend = '0;
    div_req.divisor  = DS'(weff);
    case (rc_state_r)
      RC_XPOS: begin
        div_req.dividend = DV'(QX'(col_r) * QX'(nnis_pkg::SRC_WIDTH));
        div_req.divisor  = DS'(weff);
      end
      RC_XSTEP: begin
        div_req.dividend = DV'(nnis_pkg::SRC_WIDTH);
        div_req.divisor  = DS'(weff);
      end
      RC_YPOS: begin
        div_req.dividend = DV'(QY'(row_r) * QY'(nnis_pkg::SRC_HEIGHT));
        div_req.divisor  = DS'(heff);
      end
      RC_YSTEP: begin
        div_req.dividend = DV'(nnis_pkg::SRC_HEIGHT);
        div_req.divisor  = DS'(heff);
      end
      default: begin
        div_req.valid = 1'b0;
      end
    endcase
  end

  nnis_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration writes. Any write marks the stepping state for rebuild.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_width_r  <= nnis_pkg::OUT_WIDTH_RESET;
      out_height_r <= nnis_pkg::OUT_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nnis_pkg::CFG_OUT_WIDTH:  out_width_r  <= cfg_data[OW-1:0];
        nnis_pkg::CFG_OUT_HEIGHT: out_height_r <= cfg_data[OH-1:0];
        default: ;
      endcase
    end
  end

  // Rebuild sequencer and output position state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r    <= 1'b1;
      rc_state_r <= RC_IDLE;
      rc_go_r    <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
      sx_r       <= '0;
      remx_r     <= '0;
      sy_r       <= '0;
      remy_r     <= '0;
      stepqx_r   <= '0;
      steprx_r   <= '0;
      stepqy_r   <= '0;
      stepry_r   <= '0;
    end else begin
      if (rc_go_r) begin
        rc_go_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        dirty_r <= 1'b1;
      end
      case (rc_state_r)
        RC_IDLE: begin
          if (dirty_r && !(cfg_valid && cfg_ready)) begin
            dirty_r    <= 1'b0;
            rc_state_r <= RC_XPOS;
            rc_go_r    <= 1'b1;
          end
        end
        RC_XPOS: begin
          if (div_rsp.done) begin
            sx_r       <= div_rsp.quot[QX-1:0];
            remx_r     <= div_rsp.rem[OW-1:0];
            rc_state_r <= RC_XSTEP;
            rc_go_r    <= 1'b1;
          end
        end
        RC_XSTEP: begin
          if (div_rsp.done) begin
            stepqx_r   <= div_rsp.quot[QX-1:0];
            steprx_r   <= div_rsp.rem[OW-1:0];
            rc_state_r <= RC_YPOS;
            rc_go_r    <= 1'b1;
          end
        end
        RC_YPOS: begin
          if (div_rsp.done) begin
            sy_r       <= div_rsp.quot[QY-1:0];
            remy_r     <= div_rsp.rem[OH-1:0];
            rc_state_r <= RC_YSTEP;
            rc_go_r    <= 1'b1;
          end
        end
        RC_YSTEP: begin
          if (div_rsp.done) begin
            stepqy_r   <= div_rsp.quot[QY-1:0];
            stepry_r   <= div_rsp.rem[OH-1:0];
            rc_state_r <= RC_IDLE;
          end
        end
        default: begin
          rc_state_r <= RC_IDLE;
        end
      endcase

      // Emits only happen while the sequencer is idle and clean.
      if (accept_emit) begin
        if (row_end) begin
          col_r  <= '0;
          sx_r   <= '0;
          remx_r <= '0;
          if (frame_end) begin
            row_r  <= '0;
            sy_r   <= '0;
            remy_r <= '0;
          end else begin
            row_r  <= row_r + 1'b1;
            sy_r   <= sy_nxt;
            remy_r <= remy_nxt;
          end
        end else begin
          col_r  <= col_r + 1'b1;
          sx_r   <= sx_nxt;
          remx_r <= remx_nxt;
        end
      end
    end
  end

  // Load pointer, wrapping after the last source pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_ptr_r <= '0;
    end else if (accept_load) begin
      if (load_ptr_r == AW'(nnis_pkg::IMG_SIZE - 1)) begin
        load_ptr_r <= '0;
      end else begin
        load_ptr_r <= load_ptr_r + 1'b1;
      end
    end
  end

  // Image memory: loads write, emits read. The read register holds its
  // word until the next emit, which keeps a stalled result safe.
  always_ff @(posedge clk) begin
    if (accept_load) begin
      img_mem[load_ptr_r] <= in_pixel_in;
    end
    if (accept_emit) begin
      rd_data_r <= img_mem[rd_addr];
    end
  end

  // Read stage and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= accept_emit || (pend_r && !pend_move);
      if (pend_move) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_emit) begin
      pend_row_end_r   <= row_end;
      pend_frame_end_r <= frame_end;
    end
    if (pend_move) begin
      out_pixel_r     <= rd_data_r;
      out_row_end_r   <= pend_row_end_r;
      out_frame_end_r <= pend_frame_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbor image scaler testbench
// Loads the source image through the input channel, asks for scaled output
// pixels under a series of window sizes, and checks every result word against
// a predictor kept inside this file. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PIX_W      = nnis_pkg::PIX_W;
  localparam int CFG_IDX_W  = nnis_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = nnis_pkg::CFG_DATA_W;
  localparam int IMG_SIZE   = nnis_pkg::IMG_SIZE;

  // Input word codes. A load word writes one source pixel, an emit word asks
  // for the next pixel of the output window.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EMIT = 1'b1;

  // Idle cycles allowed before a register write once the last result has
  // arrived. A load word has no result, so the block may still be busy with
  // it; the margin here covers that.
  localparam int SETTLE_CYCLES  = 8;
  // Longest run of cycles with no handshake at all before the run is called
  // hung. The slowest legal stretch is the divider pass after a register
  // write plus the longest random gap on either side.
  localparam int WATCHDOG_LIMIT = 4000;
  // Number of random items after the directed part.
  localparam int RANDOM_ITEMS   = 1350;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pix;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             frame_end;
  } scaled_px_t;

  // Clock, reset and all block inputs start at known values.
  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_mode     = MODE_LOAD;
  logic [PIX_W-1:0]      in_pixel_in = '0;
  logic                  out_stall   = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = nnis_pkg::CFG_OUT_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  logic                  in_stall;
  logic                  out_valid;
  logic [PIX_W-1:0]      out_pixel_out;
  logic                  out_row_end;
  logic                  out_frame_end;
  logic                  cfg_ready;

  nearest_neighbor_image_scaler u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_pixel_in  (in_pixel_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel_out(out_pixel_out),
    .out_row_end  (out_row_end),
    .out_frame_end(out_frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // Words waiting to be driven, and result words that the scaler owes us.
  in_word_t   words_pending[$];
  scaled_px_t pixels_due[$];

  // Predictor state, updated at the clock edge where a word or a register
  // write is accepted.
  logic [PIX_W-1:0] img_mem [IMG_SIZE];
  int ld_ptr, cur_col, cur_row, win_w, win_h;

  // Planning state used while words are queued. It follows the same sequence
  // as the predictor and also remembers which source pixels have been
  // written, so that no emit word ever reads a pixel that was never loaded.
  bit plan_written [IMG_SIZE];
  int plan_ptr = 0;
  int plan_col = 0;
  int plan_row = 0;
  int plan_w   = int'(nnis_pkg::OUT_WIDTH_RESET);
  int plan_h   = int'(nnis_pkg::OUT_HEIGHT_RESET);

  // Handshake seen at the last rising edge, and idling controls per phase.
  bit in_fire   = 1'b0;
  bit in_quiet  = 1'b0;
  bit out_quiet = 1'b0;
  int in_gap    = 0;
  int stall_left = 0;

  int quiet_cycles = 0;
  int mismatches   = 0;
  int n_loads      = 0;
  int n_emits      = 0;
  int n_row_ends   = 0;
  int n_frame_ends = 0;
  int n_cfg        = 0;

  // A window size of zero behaves as a size of one.
  function automatic int eff_span(int v);
    return (v == 0) ? 1 : v;
  endfunction

  // Nearest source index for an output position. A counter left beyond the
  // window by a shrink lands past the image and is clamped to the last index.
  function automatic int scale_pos(int pos, int src, int span);
    int s;
    s = (pos * src) / span;
    if (s >= src) s = src - 1;
    return s;
  endfunction

  function automatic int map_addr(int row, int col, int w, int h);
    return scale_pos(row, nnis_pkg::SRC_HEIGHT, h) * nnis_pkg::SRC_WIDTH +
           scale_pos(col, nnis_pkg::SRC_WIDTH, w);
  endfunction

  // Moves the output position on by one pixel and returns {row_end, frame_end}.
  // A counter at or past the last position counts as being at the end.
  function automatic logic [1:0] advance_pos(inout int row, inout int col,
                                             input int w, input int h);
    logic at_row_end, at_frame_end;
    at_row_end   = (col + 1 >= w);
    at_frame_end = at_row_end && (row + 1 >= h);
    if (at_frame_end) begin
      row = 0;
      col = 0;
    end else if (at_row_end) begin
      row = row + 1;
      col = 0;
    end else begin
      col = col + 1;
    end
    return {at_row_end, at_frame_end};
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = int'($urandom_range(99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(3, 1));
    if (r < 97) return int'($urandom_range(12, 4));
    return int'($urandom_range(40, 20));
  endfunction

  // Width values lean toward small windows so that frames complete often.
  // Bit 8 of the write data is set now and then; the width register drops it.
  function automatic logic [CFG_DATA_W-1:0] pick_width();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 9'd1;
      2:       return 9'd240;
      3:       return 9'h100 | CFG_DATA_W'($urandom_range(255));
      4, 5, 6: return CFG_DATA_W'($urandom_range(16, 1));
      default: return CFG_DATA_W'($urandom_range(240, 1));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_height();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 9'd1;
      2:       return 9'd320;
      3:       return 9'd511;
      4, 5, 6: return CFG_DATA_W'($urandom_range(16, 1));
      default: return CFG_DATA_W'($urandom_range(320, 1));
    endcase
  endfunction

  task automatic queue_load(input logic [PIX_W-1:0] pix);
    in_word_t word;
    word.mode = MODE_LOAD;
    word.pix  = pix;
    words_pending.push_back(word);
    plan_written[plan_ptr] = 1'b1;
    plan_ptr = (plan_ptr + 1) % IMG_SIZE;
  endtask

  // Queues an emit word if the pixel it will read has been loaded, and a
  // load of random content otherwise. The pixel field of an emit is random,
  // since the scaler must ignore it.
  task automatic queue_emit();
    in_word_t word;
    int w, h;
    w = eff_span(plan_w);
    h = eff_span(plan_h);
    if (plan_written[map_addr(plan_row, plan_col, w, h)]) begin
      word.mode = MODE_EMIT;
      word.pix  = PIX_W'($urandom);
      words_pending.push_back(word);
      void'(advance_pos(plan_row, plan_col, w, h));
    end else begin
      queue_load(PIX_W'($urandom));
    end
  endtask

  // Waits until every queued word is taken and every result is back, then
  // lets the pipeline drain. Polling at the falling edge keeps this clear of
  // the updates made at the rising edge.
  task automatic wait_idle();
    while (words_pending.size() != 0 || in_valid || pixels_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == nnis_pkg::CFG_OUT_WIDTH) plan_w = int'(data[nnis_pkg::OW_W-1:0]);
    else if (idx == nnis_pkg::CFG_OUT_HEIGHT) plan_h = int'(data[nnis_pkg::OH_W-1:0]);
  endtask

  // Random traffic: mostly runs of emit words, broken up by bursts of loads
  // that refresh part of the image, and the odd single load in between.
  task automatic random_phase(input int count);
    int done, burst;
    done = 0;
    while (done < count) begin
      case ($urandom_range(19))
        0, 1:    burst = int'($urandom_range(48, 1));
        2:       burst = 1;
        default: burst = 0;
      endcase
      if (burst > 0) begin
        repeat (burst) queue_load(PIX_W'($urandom));
      end else begin
        burst = int'($urandom_range(32, 1));
        repeat (burst) queue_emit();
      end
      done += burst;
    end
  endtask

  // Driver: puts the next word on the input channel at the falling edge once
  // the current one has been taken, with a random gap after each word. The
  // payload stays put while the scaler stalls.
  always @(negedge clk) begin
    in_word_t word;
    if (rst_n && (!in_valid || in_fire)) begin
      if (in_gap > 0 || words_pending.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid <= 1'b0;
      end else begin
        word = words_pending.pop_front();
        in_valid    <= 1'b1;
        in_mode     <= word.mode;
        in_pixel_in <= word.pix;
        in_gap = pick_gap(in_quiet);
      end
    end
  end

  // Receiver back-pressure: free cycles alternate with stalls of random length.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap(out_quiet);
    end
  end

  // Monitor: at each rising edge, checks an accepted result word against the
  // oldest expectation, runs the predictor on an accepted input word, and
  // tracks register writes. A watchdog ends the run if nothing moves.
  always @(posedge clk) begin
    scaled_px_t want;
    scaled_px_t got;
    logic [1:0] flags;
    int w, h;
    bit moved;
    if (!rst_n) begin
      ld_ptr       = 0;
      cur_col      = 0;
      cur_row      = 0;
      win_w        = int'(nnis_pkg::OUT_WIDTH_RESET);
      win_h        = int'(nnis_pkg::OUT_HEIGHT_RESET);
      in_fire      = 1'b0;
      quiet_cycles = 0;
    end else begin
      moved   = 1'b0;
      in_fire = in_valid && !in_stall;

      if (out_valid && !out_stall) begin
        moved = 1'b1;
        got   = {out_pixel_out, out_row_end, out_frame_end};
        if (pixels_due.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing expected: pixel=%h row_end=%b frame_end=%b",
                   $time, got.pixel, got.row_end, got.frame_end);
        end else begin
          want = pixels_due.pop_front();
          if (got.pixel !== want.pixel) begin
            mismatches++;
            $display("%0t: pixel_out expected %h, got %h", $time, want.pixel, got.pixel);
          end
          if (got.row_end !== want.row_end) begin
            mismatches++;
            $display("%0t: row_end expected %b, got %b", $time, want.row_end, got.row_end);
          end
          if (got.frame_end !== want.frame_end) begin
            mismatches++;
            $display("%0t: frame_end expected %b, got %b",
                     $time, want.frame_end, got.frame_end);
          end
        end
      end

      if (in_fire) begin
        moved = 1'b1;
        if (in_mode == MODE_LOAD) begin
          img_mem[ld_ptr] = in_pixel_in;
          ld_ptr = (ld_ptr + 1) % IMG_SIZE;
          n_loads++;
        end else begin
          w = eff_span(win_w);
          h = eff_span(win_h);
          want.pixel     = img_mem[map_addr(cur_row, cur_col, w, h)];
          flags          = advance_pos(cur_row, cur_col, w, h);
          want.row_end   = flags[1];
          want.frame_end = flags[0];
          pixels_due.push_back(want);
          n_emits++;
          if (flags[1]) n_row_ends++;
          if (flags[0]) n_frame_ends++;
        end
      end

      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        n_cfg++;
        if (cfg_index == nnis_pkg::CFG_OUT_WIDTH)
          win_w = int'(cfg_data[nnis_pkg::OW_W-1:0]);
        else if (cfg_index == nnis_pkg::CFG_OUT_HEIGHT)
          win_h = int'(cfg_data[nnis_pkg::OH_W-1:0]);
      end

      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results still owed",
                 $time, quiet_cycles, pixels_due.size());
        $display("nearest_neighbor_image_scaler test failed");
        $finish;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int done, n;

    // Synchronous reset, released at a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Extreme pixel values, then the first pixels of the reset-size window,
    // which only read what has just been loaded.
    queue_load(16'h0000);
    queue_load(16'hFFFF);
    queue_load(16'hAAAA);
    queue_load(16'h5555);
    repeat (5) queue_emit();
    // Complete the first source row, which the first output row of any
    // window reads from. Later emits load what they need as they go.
    repeat (nnis_pkg::SRC_WIDTH - 4) queue_load(PIX_W'($urandom));

    // Zero sizes act as a one-pixel window. The first emit also finds the
    // column counter past the shrunk window, so it is clamped and wraps.
    write_reg(nnis_pkg::CFG_OUT_WIDTH, '0);
    write_reg(nnis_pkg::CFG_OUT_HEIGHT, '0);
    repeat (2) queue_emit();

    // A 240 by 320 window.
    write_reg(nnis_pkg::CFG_OUT_WIDTH, 9'd240);
    write_reg(nnis_pkg::CFG_OUT_HEIGHT, 9'd320);
    repeat (3) queue_emit();

    // All-ones write data: width keeps only its low eight bits.
    write_reg(nnis_pkg::CFG_OUT_WIDTH, 9'h1FF);
    write_reg(nnis_pkg::CFG_OUT_HEIGHT, 9'h1FF);
    repeat (2) queue_emit();

    // A tiny one-row window runs through full frames and wraps.
    write_reg(nnis_pkg::CFG_OUT_WIDTH, 9'd3);
    write_reg(nnis_pkg::CFG_OUT_HEIGHT, 9'd1);
    repeat (7) queue_emit();

    // Walk a few rows down, then shrink the height under the row counter.
    write_reg(nnis_pkg::CFG_OUT_WIDTH, 9'd2);
    write_reg(nnis_pkg::CFG_OUT_HEIGHT, 9'd200);
    repeat (5) queue_emit();
    write_reg(nnis_pkg::CFG_OUT_HEIGHT, 9'd1);
    repeat (2) queue_emit();

    // Random phases. Each one may change either register while the block is
    // idle, which often leaves the counters beyond a smaller window, and picks
    // its own idling so that some phases run at full rate.
    done = 0;
    while (done < RANDOM_ITEMS) begin
      if ($urandom_range(3) != 0) write_reg(nnis_pkg::CFG_OUT_WIDTH, pick_width());
      if ($urandom_range(3) != 0) write_reg(nnis_pkg::CFG_OUT_HEIGHT, pick_height());
      in_quiet  = ($urandom_range(9) < 3);
      out_quiet = ($urandom_range(9) < 3);
      n = int'($urandom_range(120, 30));
      random_phase(n);
      done += n;
    end

    wait_idle();
    $display("Run covered %0d loads and %0d emitted pixels (%0d row ends, %0d frame ends)",
             n_loads, n_emits, n_row_ends, n_frame_ends);
    $display("across %0d register writes; %0d mismatches.", n_cfg, mismatches);
    if (mismatches == 0) begin
      $display("nearest_neighbor_image_scaler test passed");
    end else begin
      $display("nearest_neighbor_image_scaler test failed");
    end
    $finish;
  end

endmodule
